// ===== rtl/core/dvf_pkg.sv =====
`timescale 1ns / 1ps
// Package for the distinct value filter: depth, widths, types and the double compare.
package dvf_pkg;

    localparam int SET_DEPTH = 16;
    localparam int CNT_W     = $clog2(SET_DEPTH + 1);
    localparam int IDX_W     = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int WORD_W    = 64;
    localparam int TOTAL_W   = 5;

    localparam logic [WORD_W-1:0] ABS_MASK  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [WORD_W-1:0] EXP_MASK  = 64'h7FF0_0000_0000_0000;
    localparam logic [WORD_W-1:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic [IDX_W-1:0]  rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic               first_seen;
        logic [WORD_W-1:0]  echo_word;
        logic [TOTAL_W-1:0] distinct_total;
        logic               final_flag;
        logic               store_full;
    } result_t;

    function automatic logic is_nan(input logic [WORD_W-1:0] w);
        is_nan = ((w & EXP_MASK) == EXP_MASK) && ((w & FRAC_MASK) != '0);
    endfunction

    function automatic logic doubles_equal(input logic [WORD_W-1:0] a,
                                           input logic [WORD_W-1:0] b);
        if (is_nan(a) || is_nan(b))
            doubles_equal = 1'b0;
        else if (((a & ABS_MASK) == '0) && ((b & ABS_MASK) == '0))
            doubles_equal = 1'b1;
        else
            doubles_equal = (a == b);
    endfunction

endpackage

// ===== rtl/core/dvf_store.sv =====
`timescale 1ns / 1ps
// Store of distinct values seen in the current set: one write port, one registered read port.
module dvf_store (
    input  logic                      clk,
    input  dvf_pkg::mem_req_t         req,
    output logic [dvf_pkg::WORD_W-1:0] rd_data
);
    import dvf_pkg::*;

    logic [WORD_W-1:0] mem [SET_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/dvf_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: scans the store one entry per cycle, then appends a new value and issues the result.
module dvf_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [dvf_pkg::WORD_W-1:0] sample_word,
    input  logic                       set_end,
    input  logic                       res_take,
    output logic                       res_valid,
    output dvf_pkg::result_t           res,
    output dvf_pkg::mem_req_t          mem_req,
    input  logic [dvf_pkg::WORD_W-1:0] mem_rd_data
);
    import dvf_pkg::*;

    ctrl_state_t       state_reg, state_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              last_reg, last_next;
    logic              found_reg, found_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;

    logic              accept;
    logic              is_new;
    logic              room;
    logic              stored;
    logic [CNT_W-1:0]  count_after;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        last_reg <= last_next;
    end

    assign is_new      = !found_reg;
    assign room        = (count_reg < CNT_W'(SET_DEPTH));
    assign stored      = is_new && room;
    assign count_after = count_reg + CNT_W'(stored);

    always_comb
    begin
        state_next  = state_reg;
        word_next   = word_reg;
        last_next   = last_reg;
        found_next  = found_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        accept      = 1'b0;
        in_stall    = 1'b1;
        res_valid   = 1'b0;

        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = count_reg[IDX_W-1:0];
        mem_req.wr_data = word_reg;
        mem_req.rd_addr = idx_reg[IDX_W-1:0];

        res.first_seen     = is_new;
        res.echo_word      = word_reg;
        res.distinct_total = TOTAL_W'(count_after);
        res.final_flag     = last_reg;
        res.store_full     = is_new && !room;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall        = 1'b0;
                accept          = in_valid;
                mem_req.rd_addr = '0;
                if (accept)
                begin
                    word_next  = sample_word;
                    last_next  = set_end;
                    found_next = 1'b0;
                    idx_next   = CNT_W'(1);
                    if (count_reg == '0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // rd data belongs to entry idx_reg - 1
                if (doubles_equal(mem_rd_data, word_reg))
                begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end
                else if (idx_reg < count_reg)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    mem_req.wr_en = stored;
                    count_next    = last_reg ? '0 : count_after;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/distinct_value_filter.sv =====
`timescale 1ns / 1ps
// Each item is compared with the N distinct values stored (0..16), read from the value
// store one entry per cycle; a match ends the scan early. A new item is taken only after
// the last result has left the sequencer. The result waits in an output register,
// so the next item is taken while it is stalled. Reset clears the count and control
// state at once; store contents are not cleared and are never read before being written.
module distinct_value_filter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [dvf_pkg::WORD_W-1:0]  sample_word,
    input  logic                        set_end,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        first_seen,
    output logic [dvf_pkg::WORD_W-1:0]  echo_word,
    output logic [dvf_pkg::TOTAL_W-1:0] distinct_total,
    output logic                        final_flag,
    output logic                        store_full
);
    import dvf_pkg::*;

    mem_req_t          mem_req;
    logic [WORD_W-1:0] mem_rd_data;
    result_t           res;
    logic              res_valid;
    logic              res_take;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    dvf_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    dvf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_word (sample_word),
        .set_end     (set_end),
        .res_take    (res_take),
        .res_valid   (res_valid),
        .res         (res),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    assign res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_take)
        begin
            out_valid_next = res_valid;
            if (res_valid)
                out_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid      = out_valid_reg;
    assign first_seen     = out_reg.first_seen;
    assign echo_word      = out_reg.echo_word;
    assign distinct_total = out_reg.distinct_total;
    assign final_flag     = out_reg.final_flag;
    assign store_full     = out_reg.store_full;

endmodule
